>>> hw/rtl/psev_pkg.sv
// Shared types and constants of the portfolio Sharpe evaluator.
package psev_pkg;

    localparam int ROW_W      = 4;
    localparam int MAX_ASSETS = 1 << ROW_W;
    localparam int COV_DEPTH  = MAX_ASSETS * MAX_ASSETS;
    localparam int WEIGHT_W   = 17;
    localparam logic [31:0] WEIGHT_ONE = 32'd65536;

    localparam logic [1:0] CMD_LOAD_COV  = 2'd0;
    localparam logic [1:0] CMD_LOAD_MEAN = 2'd1;
    localparam logic [1:0] CMD_WEIGHT    = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ROW_W-1:0]  row_index;
        logic [ROW_W-1:0]  col_index;
        logic signed [31:0] value;
        logic              last_weight;
    } t_in;

    typedef struct packed {
        logic signed [31:0] port_return;
        logic [31:0]        port_risk;
        logic signed [31:0] sharpe;
        logic               sharpe_valid;
        logic               is_best;
        logic signed [31:0] best_sharpe;
        logic [31:0]        portfolio_number;
    } t_out;

endpackage

>>> hw/rtl/psev_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psev_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/psev_sqrt.sv
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
module psev_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_val;
    logic [35:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] n_shift;
    logic [35:0] n_trial;

    always_comb begin
        n_shift = {r_rem[33:0], r_val[63:62]};
        n_trial = {2'b00, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val <= {r_val[61:0], 2'b00};
                if (n_shift >= n_trial) begin
                    r_rem  <= n_shift - n_trial;
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= n_shift;
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

>>> hw/rtl/psev_div.sv
// Restoring divider: 49-bit magnitude by 32-bit divisor, one quotient bit per cycle.
module psev_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [48:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [48:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [48:0] r_dvd;
    logic [31:0] r_dsr;
    logic [31:0] r_rem;
    logic [48:0] r_quot;
    logic [32:0] n_shift;
    logic        n_ge;

    always_comb begin
        n_shift = {r_rem, r_dvd[48]};
        n_ge    = n_shift >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[47:0], 1'b0};
                if (n_ge) begin
                    r_rem <= 32'(n_shift - {1'b0, r_dsr});
                end else begin
                    r_rem <= n_shift[31:0];
                end
                r_quot <= {r_quot[47:0], n_ge};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd48) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

>>> hw/rtl/portfolio_sharpe_evaluator.sv
// Top level of the portfolio Sharpe evaluator.
//
// Load transactions (covariance or mean) write the tables on acceptance; every
// load also drops any partial portfolio and clears best-Sharpe tracking and the
// portfolio count. A weight transaction walks all 16 assets through the covariance
// memories (a normal and a transposed copy, so both cov[k][j] and cov[j][k] come out
// of the same read), the weight memory and the mean memory, then drains the
// multiply-accumulate pipeline. On the weight marked last, a bit-serial square root
// and a bit-serial divider follow when the variance is positive, before the result
// enters the output register. The result register frees the input side: further
// weights and loads are taken while a result waits to be taken. Tables hold no
// reset value; reading an entry never loaded gives undefined fields. The
// configuration port is always ready; write risk_free_rate only while the
// block is idle.
module portfolio_sharpe_evaluator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  psev_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output psev_pkg::t_out       o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic signed [31:0]   i_cfg_data
);
    import psev_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_SQRT  = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    localparam int COV_AW = 2 * ROW_W;

    t_state r_state, n_state;

    logic signed [31:0] r_rf;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_j;
    logic [WEIGHT_W-1:0] r_w;
    logic               r_last;
    logic [MAX_ASSETS-1:0] r_present;
    logic [63:0]        r_ret_acc;
    logic [63:0]        r_var_acc;
    logic signed [31:0] r_best;
    logic               r_best_seen;
    logic [31:0]        r_count;
    logic [1:0]         r_drain;

    // accumulate pipeline
    logic               r_s1_v, r_s1_diag, r_s1_en, r_s1_first;
    logic               r_s2_v, r_s2_m, r_s3_v;
    logic [WEIGHT_W-1:0] r_p;
    logic signed [32:0] r_c;
    logic signed [49:0] r_mp;
    logic signed [50:0] r_prod;

    // finish path
    logic [31:0]        r_risk;
    logic               r_neg;
    logic signed [31:0] r_sharpe;
    logic               r_valid;
    logic               r_out_valid;
    t_out               r_out;

    logic in_acc;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ---- memories ----
    logic        is_load_cov, is_load_mean, is_weight;
    logic [31:0] cov_q, covt_q, mean_q;
    logic [WEIGHT_W-1:0] w_q;
    logic        w_we;

    assign is_load_cov  = in_acc && (i_in_data.cmd == CMD_LOAD_COV);
    assign is_load_mean = in_acc && (i_in_data.cmd == CMD_LOAD_MEAN);
    assign is_weight    = in_acc && (i_in_data.cmd == CMD_WEIGHT);
    assign w_we         = (r_state == S_DRAIN) && (r_drain == 2'd0);

    psev_ram #(.WIDTH(32), .DEPTH(COV_DEPTH)) u_cov (
        .i_clk   (i_clk),
        .i_we    (is_load_cov),
        .i_waddr ({i_in_data.row_index, i_in_data.col_index}),
        .i_wdata (i_in_data.value),
        .i_raddr (COV_AW'({r_row, r_j})),
        .o_rdata (cov_q)
    );

    // transposed copy: entry [col][row]
    psev_ram #(.WIDTH(32), .DEPTH(COV_DEPTH)) u_cov_t (
        .i_clk   (i_clk),
        .i_we    (is_load_cov),
        .i_waddr ({i_in_data.col_index, i_in_data.row_index}),
        .i_wdata (i_in_data.value),
        .i_raddr (COV_AW'({r_row, r_j})),
        .o_rdata (covt_q)
    );

    psev_ram #(.WIDTH(32), .DEPTH(MAX_ASSETS)) u_mean (
        .i_clk   (i_clk),
        .i_we    (is_load_mean),
        .i_waddr (i_in_data.row_index),
        .i_wdata (i_in_data.value),
        .i_raddr (r_row),
        .o_rdata (mean_q)
    );

    psev_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_ASSETS)) u_weight (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (r_w),
        .i_raddr (r_j),
        .o_rdata (w_q)
    );

    // ---- clamp incoming weight to 0..1.0 ----
    logic [WEIGHT_W-1:0] w_clamp;
    always_comb begin
        if (i_in_data.value[31]) begin
            w_clamp = '0;
        end else if ($unsigned(i_in_data.value) > WEIGHT_ONE) begin
            w_clamp = WEIGHT_W'(WEIGHT_ONE);
        end else begin
            w_clamp = i_in_data.value[WEIGHT_W-1:0];
        end
    end

    // ---- stage 2 terms ----
    logic [WEIGHT_W-1:0]  w_sel;
    logic [2*WEIGHT_W-1:0] ww;
    logic signed [32:0]   c_sum;
    always_comb begin
        w_sel = r_s1_diag ? r_w : w_q;
        ww    = r_w * w_sel;
        if (r_s1_diag) begin
            c_sum = {cov_q[31], cov_q};
        end else begin
            c_sum = $signed({cov_q[31], cov_q}) + $signed({covt_q[31], covt_q});
        end
    end

    // ---- finish arithmetic ----
    logic signed [47:0] ret48;
    logic signed [31:0] ret_sat;
    logic               var_pos;
    logic signed [32:0] num;
    logic [32:0]        num_mag;
    always_comb begin
        ret48 = $signed(r_ret_acc[63:16]);
        if (ret48 > 48'sd2147483647) begin
            ret_sat = 32'sh7fffffff;
        end else if (ret48 < -48'sd2147483648) begin
            ret_sat = 32'sh80000000;
        end else begin
            ret_sat = ret48[31:0];
        end
        var_pos = !r_var_acc[63] && (|r_var_acc);
        num     = $signed({ret_sat[31], ret_sat}) - $signed({r_rf[31], r_rf});
        num_mag = num[32] ? 33'(-num) : 33'(num);
    end

    logic        sq_start, sq_done, dv_start, dv_done;
    logic [31:0] sq_root;
    logic [48:0] dv_quot;

    assign sq_start = (r_state == S_DRAIN) && (r_drain == 2'd3) && r_last && var_pos;
    assign dv_start = (r_state == S_SQRT) && sq_done;

    psev_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_var_acc),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    psev_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend ({num_mag, 16'h0000}),
        .i_divisor  (sq_root),
        .o_done     (dv_done),
        .o_quot     (dv_quot)
    );

    // saturate the signed quotient
    logic signed [31:0] q_sat;
    always_comb begin
        if (!r_neg) begin
            q_sat = (dv_quot > 49'd2147483647) ? 32'sh7fffffff : $signed(dv_quot[31:0]);
        end else begin
            q_sat = (dv_quot > 49'd2147483648) ? 32'sh80000000 : $signed(32'(-dv_quot));
        end
    end

    // best tracking for the finishing portfolio
    logic               beat;
    logic               out_free;
    assign beat     = r_valid && (!r_best_seen || (r_sharpe > r_best));
    assign out_free = !r_out_valid || !i_out_stall;

    // ---- state machine ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (is_weight) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (&r_j) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == 2'd3) begin
                    if (!r_last) begin
                        n_state = S_IDLE;
                    end else if (var_pos) begin
                        n_state = S_SQRT;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SQRT: begin
                if (sq_done) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (dv_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rf        <= '0;
            r_present   <= '0;
            r_ret_acc   <= '0;
            r_var_acc   <= '0;
            r_best      <= 32'sh80000000;
            r_best_seen <= 1'b0;
            r_count     <= '0;
            r_j         <= '0;
            r_drain     <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s2_m      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_rf <= i_cfg_data;
            end

            // refill the result register on finish, else drop a taken result
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // loads clear the portfolio and the tracking
            if (is_load_cov || is_load_mean) begin
                r_present   <= '0;
                r_ret_acc   <= '0;
                r_var_acc   <= '0;
                r_best      <= 32'sh80000000;
                r_best_seen <= 1'b0;
                r_count     <= '0;
            end

            if (is_weight) begin
                r_row  <= i_in_data.row_index;
                r_w    <= w_clamp;
                r_last <= i_in_data.last_weight;
                r_j    <= '0;
            end

            // issue one table read per asset
            if (r_state == S_WALK) begin
                r_j <= r_j + ROW_W'(1);
            end
            r_s1_v     <= (r_state == S_WALK);
            r_s1_diag  <= (r_j == r_row);
            r_s1_en    <= r_present[r_j] || (r_j == r_row);
            r_s1_first <= (r_j == '0);

            // stage 2: weight product, covariance pair and weighted mean
            r_s2_v <= r_s1_v && r_s1_en;
            r_s2_m <= r_s1_v && r_s1_first;
            r_p    <= ww[2*WEIGHT_W-2:16];
            r_c    <= c_sum;
            r_mp   <= $signed({1'b0, r_w}) * $signed(mean_q);

            // stage 3: quadratic term; accumulate return and variance
            r_s3_v <= r_s2_v;
            r_prod <= $signed({1'b0, r_p}) * r_c;
            if (r_s2_m) begin
                r_ret_acc <= r_ret_acc + {{14{r_mp[49]}}, r_mp};
            end
            if (r_s3_v) begin
                r_var_acc <= r_var_acc + {{13{r_prod[50]}}, r_prod};
            end

            // drain; record the weight as present and clear the finish results
            if (r_state == S_DRAIN) begin
                r_drain <= r_drain + 2'd1;
                if (r_drain == 2'd0) begin
                    r_present[r_row] <= 1'b1;
                end
                if (r_drain == 2'd3) begin
                    r_risk  <= '0;
                    r_valid <= 1'b0;
                    r_sharpe <= '0;
                end
            end else begin
                r_drain <= '0;
            end

            if (dv_start) begin
                r_risk  <= sq_root;
                r_neg   <= num[32];
            end
            if ((r_state == S_DIV) && dv_done) begin
                r_sharpe <= q_sat;
                r_valid  <= 1'b1;
            end

            // finish: load result register, update tracking, clear portfolio
            if ((r_state == S_FIN) && out_free) begin
                r_out.port_return      <= ret_sat;
                r_out.port_risk        <= r_risk;
                r_out.sharpe           <= r_sharpe;
                r_out.sharpe_valid     <= r_valid;
                r_out.is_best          <= beat;
                r_out.best_sharpe      <= beat ? r_sharpe : r_best;
                r_out.portfolio_number <= r_count + 32'd1;
                r_count                <= r_count + 32'd1;
                if (beat) begin
                    r_best      <= r_sharpe;
                    r_best_seen <= 1'b1;
                end
                r_present <= '0;
                r_ret_acc <= '0;
                r_var_acc <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

>>> verif/testbench.sv
// Testbench of the portfolio Sharpe evaluator: random driver, checking monitor, model.
module testbench;
    import psev_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in         in_data;
    logic        out_valid;
    logic        out_stall;
    t_out        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic signed [31:0] cfg_data;

    portfolio_sharpe_evaluator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Transactions waiting to be offered, and results the model says must come out.
    t_in  pending_items[$];
    t_out expected_sharpe[$];
    int   error_count = 0;

    // Model state of the block.
    logic signed [31:0] rfr_m = 0;
    logic [31:0]        cov_m [COV_DEPTH];
    logic [31:0]        mean_m [MAX_ASSETS];
    logic [16:0]        wgt_m [MAX_ASSETS];
    bit                 present_m [MAX_ASSETS];
    logic signed [63:0] ret_acc = 0;
    logic signed [63:0] var_acc = 0;
    logic signed [31:0] best_m = 32'sh80000000;
    bit                 best_seen_m = 0;
    logic [31:0]        count_m = 0;

    function automatic logic signed [63:0] sat32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Append one transaction to the driver's queue.
    task automatic add_item(t_in it);
        pending_items = {pending_items, it};
    endtask

    // Advance the model by one accepted transaction; queue a result on the last weight.
    task automatic portfolio_step(t_in it);
        logic signed [63:0] w;
        logic signed [63:0] p;
        logic signed [63:0] c;
        logic signed [63:0] ret;
        logic signed [63:0] num;
        logic signed [63:0] sh;
        logic [63:0]        risk;
        t_out               o;
        int                 k;
        k = it.row_index;
        if (it.cmd == CMD_LOAD_COV || it.cmd == CMD_LOAD_MEAN) begin
            if (it.cmd == CMD_LOAD_COV) cov_m[k * MAX_ASSETS + it.col_index] = it.value;
            else mean_m[k] = it.value;
            ret_acc = 0;
            var_acc = 0;
            foreach (present_m[j]) present_m[j] = 0;
            best_m = 32'sh80000000;
            best_seen_m = 0;
            count_m = 0;
            return;
        end
        if (it.cmd != CMD_WEIGHT) return;
        // Clamp the weight into 0..1.0 before use.
        if (it.value < 0) w = 0;
        else if (it.value > 32'sd65536) w = 65536;
        else w = it.value;
        ret_acc = ret_acc + w * $signed(mean_m[k]);
        for (int j = 0; j < MAX_ASSETS; j++) begin
            if (present_m[j] && j != k) begin
                p = (w * $signed({47'd0, wgt_m[j]})) >>> 16;
                c = 64'($signed(cov_m[k * MAX_ASSETS + j]))
                  + 64'($signed(cov_m[j * MAX_ASSETS + k]));
                var_acc = var_acc + p * c;
            end
        end
        p = (w * w) >>> 16;
        var_acc = var_acc + p * 64'($signed(cov_m[k * MAX_ASSETS + k]));
        wgt_m[k] = w[16:0];
        present_m[k] = 1;
        if (!it.last_weight) return;

        ret = sat32(ret_acc >>> 16);
        risk = (var_acc > 0) ? int_sqrt(var_acc) : 64'd0;
        o = '0;
        o.port_return = ret[31:0];
        o.port_risk = risk[31:0];
        if (risk != 0) begin
            num = ret - 64'(rfr_m);
            sh = sat32((num * 64'sd65536) / $signed(risk));
            o.sharpe = sh[31:0];
            o.sharpe_valid = 1;
            if (!best_seen_m || $signed(sh[31:0]) > best_m) begin
                o.is_best = 1;
                best_seen_m = 1;
                best_m = sh[31:0];
            end
        end
        count_m = count_m + 1;
        o.best_sharpe = best_m;
        o.portfolio_number = count_m;
        expected_sharpe = {expected_sharpe, o};
        ret_acc = 0;
        var_acc = 0;
        foreach (present_m[j]) present_m[j] = 0;
    endtask

    // Driver: offer queued transactions with random gaps; bursts run with none.
    int send_gap = 0;
    int send_count = 0;
    bit send_burst = 0;
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
        end else begin
            busy = in_valid;
            if (in_valid && !in_stall) begin
                portfolio_step(in_data);
                busy = 0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    in_data <= pending_items.pop_front();
                    busy = 1;
                    send_count++;
                    if (send_count % 97 == 0) send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 18);
                end
            end
            in_valid <= busy;
        end
    end

    // Long receiver hold-off in the middle of a weight stream, so the block fills up
    // and stalls its input while the driver keeps offering.
    bit hold_off = 1'b0;
    initial begin
        wait (send_count >= 700);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (3000) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Monitor: accept results with random stalls and check each against the model.
    int  recv_gap = 0;
    int  recv_count = 0;
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            out_stall <= 1'b1;
        end else begin
            if (out_valid && !out_stall) begin
                recv_count++;
                if (expected_sharpe.size() == 0) begin
                    $error("result with none expected: %p", out_data);
                    error_count++;
                end else begin
                    e = expected_sharpe.pop_front();
                    if (out_data.port_return !== e.port_return) begin
                        $error("port_return exp %0d got %0d", e.port_return,
                               out_data.port_return);
                        error_count++;
                    end
                    if (out_data.port_risk !== e.port_risk) begin
                        $error("port_risk exp %0d got %0d", e.port_risk, out_data.port_risk);
                        error_count++;
                    end
                    if (out_data.sharpe !== e.sharpe) begin
                        $error("sharpe exp %0d got %0d", e.sharpe, out_data.sharpe);
                        error_count++;
                    end
                    if (out_data.sharpe_valid !== e.sharpe_valid) begin
                        $error("sharpe_valid exp %0d got %0d", e.sharpe_valid,
                               out_data.sharpe_valid);
                        error_count++;
                    end
                    if (out_data.is_best !== e.is_best) begin
                        $error("is_best exp %0d got %0d", e.is_best, out_data.is_best);
                        error_count++;
                    end
                    if (out_data.best_sharpe !== e.best_sharpe) begin
                        $error("best_sharpe exp %0d got %0d", e.best_sharpe,
                               out_data.best_sharpe);
                        error_count++;
                    end
                    if (out_data.portfolio_number !== e.portfolio_number) begin
                        $error("portfolio_number exp %0d got %0d", e.portfolio_number,
                               out_data.portfolio_number);
                        error_count++;
                    end
                end
                recv_gap = (recv_count % 53 < 15) ? 0 : $urandom_range(0, 18);
            end else if (recv_gap > 0) begin
                recv_gap--;
            end
            out_stall <= hold_off || (recv_gap != 0);
        end
    end

    function automatic t_in mk(logic [1:0] cmd, int row, int col, logic [31:0] v, bit last);
        t_in it;
        it.cmd = cmd;
        it.row_index = row[3:0];
        it.col_index = col[3:0];
        it.value = v;
        it.last_weight = last;
        return it;
    endfunction

    // Fill both tables; mode 0 gives fully random covariances, other modes well-conditioned ones; mode 2 random means.
    task automatic load_tables(int mode);
        logic [31:0] v;
        for (int r = 0; r < MAX_ASSETS; r++) begin
            for (int c = 0; c < MAX_ASSETS; c++) begin
                if (mode == 0) v = $urandom();
                else if (r == c) v = $urandom_range(1 << 12, 1 << 22);
                else v = $signed($urandom_range(0, 1 << 14)) - (1 << 13);
                add_item(mk(CMD_LOAD_COV, r, c, v, 0));
            end
            v = (mode == 2) ? $urandom() : ($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            add_item(mk(CMD_LOAD_MEAN, r, 0, v, 0));
        end
    endtask

    function automatic logic [31:0] rand_weight();
        int s;
        s = $urandom_range(0, 9);
        if (s == 0) return $urandom();
        if (s == 1) return 32'd65536;
        if (s == 2) return 32'd0;
        return $urandom_range(0, 65536);
    endfunction

    // Wait until the block has drained, then let its longest latency pass.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_sharpe.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_rfr(logic signed [31:0] v);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rfr_m = v;
    endtask

    initial begin
        logic signed [31:0] rates [5];
        int n;
        int a;
        cfg_valid = 1'b0;
        cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rates[0] = 32'sh80000000;
        rates[1] = 32'sh7fffffff;
        rates[2] = 0;
        rates[3] = $urandom();
        rates[4] = $signed($urandom_range(0, 1 << 18)) - (1 << 17);

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            write_rfr(rates[ph]);
            // Later rates reuse the last tables.
            if (ph < 3) load_tables(ph);
            if (ph == 0) begin
                // Extremes: saturated mean, clamped weights, zero risk, cmd 3, repeats.
                add_item(mk(CMD_LOAD_MEAN, 0, 0, 32'h7fffffff, 0));
                add_item(mk(CMD_LOAD_MEAN, 1, 0, 32'h80000000, 0));
                add_item(mk(CMD_LOAD_COV, 5, 5, 32'd0, 0));
                add_item(mk(CMD_LOAD_COV, 15, 15, 32'h7fffffff, 0));
                add_item(mk(CMD_LOAD_COV, 0, 15, 32'h80000000, 0));
                add_item(mk(CMD_WEIGHT, 0, 0, 32'd65536, 1));
                add_item(mk(CMD_WEIGHT, 1, 0, 32'h7fffffff, 1));
                add_item(mk(CMD_WEIGHT, 5, 0, 32'd40000, 1));
                add_item(mk(CMD_WEIGHT, 3, 0, 32'hffffffff, 1));
                add_item(mk(CMD_WEIGHT, 15, 0, 32'd65536, 0));
                add_item(mk(CMD_WEIGHT, 0, 7, 32'h80000000, 0));
                add_item(mk(2'd3, 4, 4, 32'h12345678, 1));
                add_item(mk(CMD_WEIGHT, 15, 0, 32'd70000, 1));
                add_item(mk(CMD_WEIGHT, 2, 0, 32'd30000, 0));
                add_item(mk(CMD_WEIGHT, 2, 0, 32'd20000, 0));
                add_item(mk(CMD_WEIGHT, 4, 0, 32'd65535, 1));
                add_item(mk(CMD_WEIGHT, 6, 0, 32'd30000, 0));
                add_item(mk(CMD_LOAD_MEAN, 6, 0, 32'h00010000, 0));
                add_item(mk(CMD_WEIGHT, 6, 0, 32'd0, 1));
            end
            // Mostly well-formed portfolios; a few noise and broken sequences.
            n = 0;
            while (n < 90) begin
                case ($urandom_range(0, 19))
                    0: add_item(mk(2'd3, $urandom(), $urandom(), $urandom(),
                                   1'($urandom_range(0, 1))));
                    1: add_item(mk(2'($urandom_range(0, 1)), $urandom(), $urandom(),
                                   $urandom(), 1'($urandom_range(0, 1))));
                    default: begin
                        a = $urandom_range(1, 6);
                        for (int i = 0; i < a; i++) begin
                            add_item(mk(CMD_WEIGHT, $urandom(), $urandom(),
                                        rand_weight(), i == a - 1));
                            n++;
                        end
                    end
                endcase
            end
        end
        wait_idle();
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 3000000);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/psev_pkg.sv
hw/rtl/psev_ram.sv
hw/rtl/psev_sqrt.sv
hw/rtl/psev_div.sv
hw/rtl/portfolio_sharpe_evaluator.sv
verif/testbench.sv
